// File: rtl/aohp_pkg.sv
// shared types, constants and class decode for the av1 obu header parser
// no dependencies
package aohp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 4;
    localparam int unsigned CLASS_W  = 3;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned HBYTES_W = 4;
    localparam int unsigned TERM_W   = 56;
    localparam int unsigned SHIFT_W  = 6;

    // header byte bit masks
    localparam logic [BYTE_W-1:0] M_FORBIDDEN = 8'h80;
    localparam logic [BYTE_W-1:0] M_KIND      = 8'h78;
    localparam logic [BYTE_W-1:0] M_EXT       = 8'h04;
    localparam logic [BYTE_W-1:0] M_HAS_SIZE  = 8'h02;
    localparam logic [BYTE_W-1:0] M_RESERVED  = 8'h01;
    // leb128 masks
    localparam logic [BYTE_W-1:0] M_LEB_DATA  = 8'h7F;
    localparam logic [BYTE_W-1:0] M_LEB_MORE  = 8'h80;
    // frame header byte, picture kind bits
    localparam logic [BYTE_W-1:0] M_FTYPE     = 8'h60;

    // obu types
    localparam logic [KIND_W-1:0] K_SEQ_HDR   = 4'd1;
    localparam logic [KIND_W-1:0] K_TD        = 4'd2;
    localparam logic [KIND_W-1:0] K_FRAME_HDR = 4'd3;
    localparam logic [KIND_W-1:0] K_TILE_GRP  = 4'd4;
    localparam logic [KIND_W-1:0] K_METADATA  = 4'd5;
    localparam logic [KIND_W-1:0] K_FRAME     = 4'd6;
    localparam logic [KIND_W-1:0] K_REDUNDANT = 4'd7;
    localparam logic [KIND_W-1:0] K_TILE_LIST = 4'd8;
    localparam logic [KIND_W-1:0] K_PADDING   = 4'd15;

    // unit classes
    localparam logic [CLASS_W-1:0] C_UNDEF    = 3'd0;
    localparam logic [CLASS_W-1:0] C_PARAM    = 3'd1;
    localparam logic [CLASS_W-1:0] C_DELIM    = 3'd2;
    localparam logic [CLASS_W-1:0] C_OTHER    = 3'd3;
    localparam logic [CLASS_W-1:0] C_METADATA = 3'd4;
    localparam logic [CLASS_W-1:0] C_I_FRAME  = 3'd5;
    localparam logic [CLASS_W-1:0] C_P_FRAME  = 3'd6;

    localparam logic [SIZE_W-1:0] SIZE_SAT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIZE,
        PH_FTYPE,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [CLASS_W-1:0]  unit_class;
        logic                primary_frame;
        logic                header_valid;
        logic [SIZE_W-1:0]   obu_size;
        logic [HBYTES_W-1:0] header_bytes;
    } t_result;

    function automatic logic [CLASS_W-1:0] class_of_kind(input logic [KIND_W-1:0] kind);
        logic [CLASS_W-1:0] cls;
        case (kind) inside
            K_SEQ_HDR:  cls = C_PARAM;
            K_TD:       cls = C_DELIM;
            K_FRAME_HDR, K_TILE_GRP, K_REDUNDANT, K_TILE_LIST, K_PADDING:
                        cls = C_OTHER;
            K_METADATA: cls = C_METADATA;
            K_FRAME:    cls = C_I_FRAME;
            default:    cls = C_UNDEF;
        endcase
        return cls;
    endfunction

endpackage

// File: rtl/aohp_if.sv
// stream channel interfaces for the av1 obu header parser
// depends on nothing but plain logic widths matching aohp_pkg
interface aohp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       start_flag;

    modport source(output valid, output byte_in, output start_flag, input ready);
    modport sink(input valid, input byte_in, input start_flag, output ready);
endinterface

interface aohp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  unit_class;
    logic        primary_frame;
    logic        header_valid;
    logic [31:0] obu_size;
    logic [3:0]  header_bytes;

    modport source(output valid, output unit_class, output primary_frame,
                   output header_valid, output obu_size, output header_bytes,
                   input ready);
    modport sink(input valid, input unit_class, input primary_frame,
                 input header_valid, input obu_size, input header_bytes,
                 output ready);
endinterface

// File: rtl/av1_obu_header_parser.sv
// av1 obu header parser: top level with input register, parse core and result register
// depends on aohp_pkg, aohp_if, aohp_parse_core, aohp_out_reg
//
// Takes an AV1 OBU one byte per word; a word with start_flag set is the OBU
// header byte and restarts parsing, dropping any header in progress. After
// the header byte the LEB128 size bytes are summed (at most MAX_SIZE_BYTES of
// them), and for a frame OBU one more byte supplies the picture kind to tell
// I from P. One result word then reports unit class, frame flag, validity,
// size and header length; later payload bytes are swallowed until the next
// start. Throughput is one byte per clock while the output register is not
// blocked: a word is taken into the input register, decoded from there
// against the parse state, and the result of its last byte is loaded into the
// output register. The only stall comes from the output register: while it
// holds a word the sink has not taken, the input register keeps its byte, or
// takes one byte if it was empty, and accepts nothing more.
module av1_obu_header_parser #(
    parameter int unsigned MAX_SIZE_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aohp_in_if.sink    i_in,
    aohp_out_if.source o_out
);
    import aohp_pkg::*;

    // input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    logic    out_busy;
    logic    step;
    logic    emit;
    logic    in_take;
    t_result result;

    // the decode stage advances unless the result register is blocked
    assign step    = r_in_valid && !out_busy;
    assign i_in.ready = !r_in_valid || !out_busy;
    assign in_take = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_in.byte_in;
            r_in_start <= i_in.start_flag;
        end
    end

    // header decode, leb128 accumulation and frame type check
    aohp_parse_core #(
        .MAX_SIZE_BYTES (MAX_SIZE_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_emit   (emit),
        .o_result (result)
    );

    // result word held until the sink takes it
    aohp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (result),
        .o_busy   (out_busy),
        .o_out    (o_out)
    );

endmodule

// File: rtl/aohp_parse_core.sv
// parse state and per-word decode: header fields, leb128 size, frame type
// depends on aohp_pkg
module aohp_parse_core #(
    parameter int unsigned MAX_SIZE_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [aohp_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_start,
    output logic                          o_emit,
    output aohp_pkg::t_result             o_result
);
    import aohp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic                r_flags_ok, n_flags_ok;
    logic [SIZE_W-1:0]   r_accum, n_accum;
    logic [HBYTES_W-1:0] r_count, n_count;
    logic                r_ovf, n_ovf;

    logic [2:0]          idx;
    logic [SHIFT_W-1:0]  shamt;
    logic [TERM_W-1:0]   term;
    logic [SIZE_W:0]     sum;
    logic                sum_ovf;
    logic [HBYTES_W-1:0] count_inc;
    logic                more;
    logic                size_last;
    logic                emit_size;
    logic                emit_ftype;
    logic                kind_ok;
    logic                td_bad;

    // leb128 term at 7 bits per size word
    assign idx       = r_count[2:0];
    assign shamt     = SHIFT_W'(idx) * SHIFT_W'(7);
    assign term      = TERM_W'(i_byte & M_LEB_DATA) << shamt;
    assign sum       = {1'b0, r_accum} + {1'b0, term[SIZE_W-1:0]};
    assign sum_ovf   = (|term[TERM_W-1:SIZE_W]) | sum[SIZE_W];
    assign count_inc = r_count + HBYTES_W'(1);
    assign more      = |(i_byte & M_LEB_MORE);
    assign size_last = !more || (count_inc >= HBYTES_W'(MAX_SIZE_BYTES));

    assign emit_size  = i_step && !i_start && (r_phase == PH_SIZE) && size_last
                        && (r_kind != K_FRAME);
    assign emit_ftype = i_step && !i_start && (r_phase == PH_FTYPE);
    assign o_emit     = emit_size || emit_ftype;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            if (i_start) begin
                n_phase = PH_SIZE;
            end else begin
                unique case (r_phase)
                    PH_SIZE: begin
                        if (size_last) begin
                            n_phase = (r_kind == K_FRAME) ? PH_FTYPE : PH_DONE;
                        end
                    end
                    PH_FTYPE: n_phase = PH_DONE;
                    PH_IDLE:  n_phase = PH_IDLE;
                    PH_DONE:  n_phase = PH_DONE;
                    default:  n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // datapath updates
    always_comb begin
        n_kind     = r_kind;
        n_flags_ok = r_flags_ok;
        n_accum    = r_accum;
        n_count    = r_count;
        n_ovf      = r_ovf;
        if (i_step) begin
            if (i_start) begin
                n_kind     = KIND_W'((i_byte & M_KIND) >> 3);
                n_flags_ok = !(|(i_byte & M_FORBIDDEN)) && !(|(i_byte & M_EXT))
                             && (|(i_byte & M_HAS_SIZE)) && !(|(i_byte & M_RESERVED));
                n_accum    = '0;
                n_count    = '0;
                n_ovf      = 1'b0;
            end else if (r_phase == PH_SIZE) begin
                n_count = count_inc;
                if (sum_ovf) begin
                    n_ovf   = 1'b1;
                    n_accum = SIZE_SAT;
                end else begin
                    n_accum = sum[SIZE_W-1:0];
                end
                // size field ran past its limit with continuation still set
                if (more && (count_inc >= HBYTES_W'(MAX_SIZE_BYTES))) begin
                    n_ovf   = 1'b1;
                    n_accum = SIZE_SAT;
                end
            end
        end
    end

    // result fields from the updated state
    assign kind_ok = (n_kind == K_SEQ_HDR) || (n_kind == K_TD)
                     || (n_kind == K_METADATA) || (n_kind == K_FRAME);
    assign td_bad  = (n_kind == K_TD) && (n_accum != '0);

    always_comb begin
        o_result.unit_class    = emit_ftype
                                 ? (((i_byte & M_FTYPE) == '0) ? C_I_FRAME : C_P_FRAME)
                                 : class_of_kind(n_kind);
        o_result.primary_frame = (n_kind == K_FRAME);
        o_result.header_valid  = n_flags_ok && !n_ovf && kind_ok && !td_bad;
        o_result.obu_size      = n_accum;
        o_result.header_bytes  = n_count + HBYTES_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_kind     <= '0;
            r_flags_ok <= 1'b0;
            r_accum    <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_flags_ok <= n_flags_ok;
            r_accum    <= n_accum;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
        end
    end

endmodule

// File: rtl/aohp_out_reg.sv
// result register feeding the output channel
// depends on aohp_pkg and aohp_if
module aohp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  aohp_pkg::t_result i_result,
    output logic              o_busy,
    aohp_out_if.source        o_out
);
    import aohp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // busy while a word is held that the sink is not taking now
    assign o_busy = r_valid && !o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.unit_class    = r_res.unit_class;
    assign o_out.primary_frame = r_res.primary_frame;
    assign o_out.header_valid  = r_res.header_valid;
    assign o_out.obu_size      = r_res.obu_size;
    assign o_out.header_bytes  = r_res.header_bytes;

endmodule

// File: sim/testbench.sv
// self-checking testbench for av1_obu_header_parser: a directed table, then random obu streams
// depends on aohp_pkg, aohp_if and the rtl top level; results checked by a local predictor or fixed rows
`timescale 1ns / 100ps

module testbench;
    import aohp_pkg::*;

    localparam int unsigned SIZE_BYTES_MAX = 8;
    localparam int DIR_ROWS = 26;
    // slack after the last expected result has arrived
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20000;

    // one input word as queued for the driver; rows of the directed table may
    // carry a hand-written result that replaces the predicted one
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       fixed;
        t_result    want;
    } t_obu_word;

    logic i_clk;
    logic i_rst_n;

    aohp_in_if  in_bus();
    aohp_out_if out_bus();

    av1_obu_header_parser #(
        .MAX_SIZE_BYTES(SIZE_BYTES_MAX)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    t_obu_word obu_bytes[$];
    t_result   expected_hdrs[$];
    t_obu_word cur_word;
    int        send_idle_pct;
    int        sink_stall_pct;
    int        mismatches;

    // predictor state, mirrors the parser registers
    t_phase      parse_ph;
    logic [3:0]  obu_kind;
    logic        hdr_ok;
    logic [31:0] leb_sum;
    logic [3:0]  leb_cnt;
    logic        leb_ovf;

    t_obu_word dir_rows [DIR_ROWS] = '{
        // idle after reset: stray byte is swallowed
        '{8'h80, 1'b0, 1'b0, '0},
        // temporal delimiter, zero size
        '{8'h12, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{C_DELIM, 1'b0, 1'b1, 32'd0, 4'd2}},
        // sequence header dropped by a new start; type 0 without size flag
        '{8'h0A, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b1, '{C_UNDEF, 1'b0, 1'b0, 32'h7F, 4'd2}},
        // frame, picture kind bits zero -> i frame
        '{8'h32, 1'b1, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{C_I_FRAME, 1'b1, 1'b1, 32'd5, 4'd2}},
        // frame with extension flag, two size bytes, p frame
        '{8'h36, 1'b1, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h20, 1'b0, 1'b1, '{C_P_FRAME, 1'b1, 1'b0, 32'd129, 4'd3}},
        // metadata with a size field that never ends: value and length overflow
        '{8'h2A, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{C_METADATA, 1'b0, 1'b0, SIZE_SAT, 4'd9}},
        // padding with reserved bit set
        '{8'h7B, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{C_OTHER, 1'b0, 1'b0, 32'd0, 4'd2}},
        // clean sequence header
        '{8'h0A, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{C_PARAM, 1'b0, 1'b1, 32'd0, 4'd2}}
    };

    function automatic logic [2:0] class_for(input logic [3:0] kind);
        case (kind)
            K_SEQ_HDR:  return C_PARAM;
            K_TD:       return C_DELIM;
            K_FRAME_HDR, K_TILE_GRP, K_REDUNDANT, K_TILE_LIST, K_PADDING:
                        return C_OTHER;
            K_METADATA: return C_METADATA;
            K_FRAME:    return C_I_FRAME;
            default:    return C_UNDEF;
        endcase
    endfunction

    // advance the predictor by one accepted byte; returns 1 when a header completes
    function automatic bit decode_obu_byte(input logic [7:0] b, input logic hdr,
                                           output t_result r);
        logic [63:0] sum;
        logic        fin;
        logic [2:0]  cls;
        r = '0;
        if (hdr) begin
            obu_kind = b[6:3];
            hdr_ok   = ((b & M_FORBIDDEN) == 0) && ((b & M_EXT) == 0)
                       && ((b & M_HAS_SIZE) != 0) && ((b & M_RESERVED) == 0);
            leb_sum  = '0;
            leb_cnt  = '0;
            leb_ovf  = 1'b0;
            parse_ph = PH_SIZE;
            return 1'b0;
        end
        if (parse_ph == PH_SIZE) begin
            sum = {32'd0, leb_sum} + (64'(b & M_LEB_DATA) << (7 * leb_cnt));
            if (sum > {32'd0, SIZE_SAT}) begin
                leb_ovf = 1'b1;
                sum = {32'd0, SIZE_SAT};
            end
            leb_sum = sum[31:0];
            leb_cnt = leb_cnt + 4'd1;
            fin = (b & M_LEB_MORE) == 0;
            // the last allowed size byte always ends the field
            if (!fin && leb_cnt >= SIZE_BYTES_MAX) begin
                leb_ovf = 1'b1;
                leb_sum = SIZE_SAT;
                fin = 1'b1;
            end
            if (!fin)
                return 1'b0;
            if (obu_kind == K_FRAME) begin
                parse_ph = PH_FTYPE;
                return 1'b0;
            end
            cls = class_for(obu_kind);
        end else if (parse_ph == PH_FTYPE) begin
            cls = ((b & M_FTYPE) == 0) ? C_I_FRAME : C_P_FRAME;
        end else begin
            return 1'b0;
        end
        r.unit_class    = cls;
        r.primary_frame = obu_kind == K_FRAME;
        r.header_valid  = hdr_ok && !leb_ovf
                          && (obu_kind inside {K_SEQ_HDR, K_TD, K_METADATA, K_FRAME})
                          && !(obu_kind == K_TD && leb_sum != 0);
        r.obu_size      = leb_sum;
        r.header_bytes  = leb_cnt + 4'd1;
        parse_ph = PH_DONE;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_word(input logic [7:0] d, input logic hdr);
        obu_bytes.push_back('{data: d, hdr: hdr, fixed: 1'b0, want: '0});
    endtask

    task automatic wait_sent();
        while (obu_bytes.size() != 0 || in_bus.valid)
            @(posedge i_clk);
    endtask

    // random obus: mostly well-formed headers with random sizes, plus flag
    // damage, truncated obus, stray bytes and payload bytes the parser skips
    task automatic run_random(input int idle_in, input int stall_out, input int n);
        int         counted;
        int         sel;
        int         nsz;
        int         cut;
        logic [3:0] kind;
        logic [7:0] hdr;
        logic [7:0] d;
        logic [7:0] seq [$];
        counted = 0;
        send_idle_pct = idle_in;
        sink_stall_pct = stall_out;
        while (counted < n) begin
            if ($urandom_range(99) < 8) begin
                push_word(8'($urandom), $urandom_range(3) == 0);
                counted++;
            end else begin
                seq.delete();
                sel = $urandom_range(15);
                if (sel < 12) begin
                    case (sel % 4)
                        0:       kind = K_SEQ_HDR;
                        1:       kind = K_TD;
                        2:       kind = K_METADATA;
                        default: kind = K_FRAME;
                    endcase
                end else begin
                    kind = 4'($urandom);
                end
                hdr = {1'b0, kind, 3'b010};
                if ($urandom_range(7) == 0)
                    hdr = hdr ^ (8'($urandom) & 8'h87);
                seq.push_back(hdr);
                sel = $urandom_range(99);
                nsz = (sel < 45) ? 1 : (sel < 75) ? 2 : (sel < 88) ? $urandom_range(3, 5)
                      : (sel < 96) ? $urandom_range(6, 8) : 9;
                for (int i = 0; i < nsz && i < SIZE_BYTES_MAX; i++) begin
                    d = 8'($urandom) & M_LEB_DATA;
                    if (i < nsz - 1)
                        d = d | M_LEB_MORE;
                    seq.push_back(d);
                end
                // single-size-byte delimiters are mostly legal, i.e. zero size
                if (kind == K_TD && nsz == 1 && $urandom_range(3) != 0)
                    seq[1] = 8'h00;
                if (kind == K_FRAME)
                    seq.push_back(8'($urandom));
                cut = ($urandom_range(9) == 0) ? $urandom_range(1, seq.size() - 1)
                                               : seq.size();
                for (int i = 0; i < cut; i++)
                    push_word(seq[i], i == 0);
                counted += cut;
                repeat ($urandom_range(3)) begin
                    push_word(8'($urandom), 1'b0);
                    counted++;
                end
            end
        end
        wait_sent();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sender: a word leaves the queue when the bus slot is free, with random gaps
    initial begin
        t_result   got_r;
        bit        has_r;
        t_obu_word nxt;
        in_bus.valid = 1'b0;
        in_bus.byte_in = '0;
        in_bus.start_flag = 1'b0;
        cur_word = '0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (in_bus.valid && in_bus.ready) begin
                    has_r = decode_obu_byte(cur_word.data, cur_word.hdr, got_r);
                    if (cur_word.fixed)
                        expected_hdrs.push_back(cur_word.want);
                    else if (has_r)
                        expected_hdrs.push_back(got_r);
                end
                if (!in_bus.valid || in_bus.ready) begin
                    if (obu_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                        nxt = obu_bytes.pop_front();
                        cur_word <= nxt;
                        in_bus.byte_in <= nxt.data;
                        in_bus.start_flag <= nxt.hdr;
                        in_bus.valid <= 1'b1;
                    end else begin
                        in_bus.valid <= 1'b0;
                    end
                end
            end
        end
    end

    // receiver: random back-pressure on the result channel
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result check: every taken word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_hdrs.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_hdrs.pop_front();
                if (out_bus.unit_class !== want.unit_class)
                    report_mismatch($sformatf("unit_class got %0d want %0d",
                                    out_bus.unit_class, want.unit_class));
                if (out_bus.primary_frame !== want.primary_frame)
                    report_mismatch($sformatf("primary_frame got %0d want %0d",
                                    out_bus.primary_frame, want.primary_frame));
                if (out_bus.header_valid !== want.header_valid)
                    report_mismatch($sformatf("header_valid got %0d want %0d",
                                    out_bus.header_valid, want.header_valid));
                if (out_bus.obu_size !== want.obu_size)
                    report_mismatch($sformatf("obu_size got %h want %h",
                                    out_bus.obu_size, want.obu_size));
                if (out_bus.header_bytes !== want.header_bytes)
                    report_mismatch($sformatf("header_bytes got %0d want %0d",
                                    out_bus.header_bytes, want.header_bytes));
            end
        end
    end

    initial begin
        int guard;
        mismatches = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        parse_ph = PH_IDLE;
        obu_kind = '0;
        hdr_ok = 1'b0;
        leb_sum = '0;
        leb_cnt = '0;
        leb_ovf = 1'b0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at full rate
        for (int i = 0; i < DIR_ROWS; i++)
            obu_bytes.push_back(dir_rows[i]);
        wait_sent();

        // random streams under each idling pattern
        run_random(0, 0, 500);
        run_random(69, 0, 500);
        run_random(0, 69, 500);
        run_random(12, 12, 500);

        guard = 0;
        while (expected_hdrs.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_hdrs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_hdrs.size()));

        if (mismatches == 0) begin
            $display("av1_obu_header_parser: match");
        end else begin
            $display("av1_obu_header_parser: mismatch");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("av1_obu_header_parser: mismatch");
        $finish;
    end

endmodule
